FILE: rtl/rnc_pkg.sv
// Shared types and constants for the replay nonce cache.
package rnc_pkg;

    localparam int unsigned DefDepth = 64;
    localparam int unsigned DefClientIdBytes = 16;
    localparam int unsigned DefNonceBytes = 16;

    localparam logic [6:0]  CapReset  = 7'd64;
    localparam logic [31:0] SkewReset = 32'd300;

    // Configuration register indexes
    localparam logic CfgCapacity = 1'b0;
    localparam logic CfgSkew     = 1'b1;

    // Result status codes
    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StInvalid = 3'd1;
    localparam logic [2:0] StSkew    = 3'd2;
    localparam logic [2:0] StReplay  = 3'd3;
    localparam logic [2:0] StCleared = 3'd4;

    // Classified command from the front part to the back part
    typedef struct packed {
        logic        clear;   // empty the store
        logic        done;    // result already known, store untouched
        logic [2:0]  status;  // status when done
        logic [63:0] cid_hi;
        logic [63:0] cid_lo;
        logic [63:0] non_hi;
        logic [63:0] non_lo;
        logic [63:0] now;
        logic [63:0] expiry;
    } t_cmd;

endpackage

FILE: rtl/rnc_front.sv
// Front part: masks the key, checks the hello and computes its expiry.
module rnc_front import rnc_pkg::*; #(
    parameter int unsigned CLIENT_ID_BYTES = DefClientIdBytes,
    parameter int unsigned NONCE_BYTES     = DefNonceBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [63:0] i_cid_hi,
    input  logic [63:0] i_cid_lo,
    input  logic [63:0] i_non_hi,
    input  logic [63:0] i_non_lo,
    input  logic [63:0] i_hello_time,
    input  logic [31:0] i_key_id,
    input  logic [63:0] i_now,
    input  logic [31:0] i_skew,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cmd        o_cmd
);
    localparam int unsigned CidBits = CLIENT_ID_BYTES * 8;
    localparam int unsigned NonBits = NONCE_BYTES * 8;

    function automatic logic [127:0] key_mask(input int unsigned nbits);
        logic [127:0] m;
        m = '0;
        for (int k = 0; k < 128; k++) begin
            if (k < nbits) m[k] = 1'b1;
        end
        return m;
    endfunction

    localparam logic [127:0] CidMask = key_mask(CidBits);
    localparam logic [127:0] NonMask = key_mask(NonBits);

    logic [127:0] w_cid, w_non;
    logic [63:0]  w_diff, w_base, w_skew, w_sum;
    logic         w_carry, w_bad;
    t_cmd         w_cmd, r_cmd;
    logic         r_valid;

    always_comb begin
        w_cid  = {i_cid_hi, i_cid_lo} & CidMask;
        w_non  = {i_non_hi, i_non_lo} & NonMask;
        w_skew = {32'd0, (i_skew == 32'd0) ? 32'd1 : i_skew};
        w_diff = (i_hello_time > i_now) ? i_hello_time - i_now : i_now - i_hello_time;
        w_base = (i_now > i_hello_time) ? i_now : i_hello_time;
        {w_carry, w_sum} = {1'b0, w_base} + {1'b0, w_skew};
        w_bad  = (w_cid == '0) || (w_non == '0) || (i_hello_time == '0) || (i_key_id == '0);
        w_cmd.clear  = i_req_type;
        w_cmd.done   = !i_req_type && (w_bad || (w_diff > w_skew));
        w_cmd.status = i_req_type ? StCleared : (w_bad ? StInvalid :
                       ((w_diff > w_skew) ? StSkew : StOk));
        w_cmd.cid_hi = w_cid[127:64];
        w_cmd.cid_lo = w_cid[63:0];
        w_cmd.non_hi = w_non[127:64];
        w_cmd.non_lo = w_non[63:0];
        w_cmd.now    = i_now;
        w_cmd.expiry = w_carry ? '1 : w_sum;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    // Hold one classified beat as the queue entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= w_cmd;
        end
    end
endmodule

FILE: rtl/rnc_back.sv
// Back part: FIFO store with purge, key search, eviction and append.
module rnc_back import rnc_pkg::*; #(
    parameter int unsigned DEPTH = DefDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    input  logic [6:0]  i_capacity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic [2:0]  o_status
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PURGE = 5'b00010,
        S_SRCH  = 5'b00100,
        S_EVICT = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    logic [319:0] r_mem [DEPTH];
    logic [319:0] r_rd;
    t_state       r_state, n_state;
    t_cmd         r_cmd;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count, r_idx, w_cap;
    logic          r_rd_ok;
    logic          r_acc;
    logic [2:0]    r_status;
    logic [AW-1:0] w_addr, w_tail;
    logic [CW:0]   w_sum;
    logic          w_match;

    // Effective capacity clamped to 1..DEPTH
    always_comb begin
        if (i_capacity == 7'd0) w_cap = CW'(1);
        else if ({25'd0, i_capacity} > 32'(DEPTH)) w_cap = CW'(DEPTH);
        else w_cap = CW'(i_capacity);
    end

    function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] t;
        t = (v >= (CW+1)'(DEPTH)) ? v - (CW+1)'(DEPTH) : v;
        return t[AW-1:0];
    endfunction

    assign w_sum   = {{(CW+1-AW){1'b0}}, r_head} + {1'b0, r_idx};
    assign w_addr  = wrap(w_sum);
    assign w_tail  = wrap({{(CW+1-AW){1'b0}}, r_head} + {1'b0, r_count});
    assign w_match = (r_rd[319:256] == r_cmd.cid_hi) && (r_rd[255:192] == r_cmd.cid_lo)
                  && (r_rd[191:128] == r_cmd.non_hi) && (r_rd[127:64] == r_cmd.non_lo);

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_accepted = r_acc;
    assign o_status   = r_status;

    // Registered memory read at head plus offset
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_addr];
        if (r_state == S_EVICT && r_count < w_cap) begin
            r_mem[w_tail] <= {r_cmd.cid_hi, r_cmd.cid_lo, r_cmd.non_hi,
                              r_cmd.non_lo, r_cmd.expiry};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = (i_cmd.clear || i_cmd.done) ? S_OUT : S_PURGE;
            S_PURGE: if (r_rd_ok && (r_count == '0 || r_rd[63:0] >= r_cmd.now))
                         n_state = S_SRCH;
            S_SRCH:  if (r_rd_ok && r_idx < r_count && w_match) n_state = S_OUT;
                     else if (r_rd_ok && r_idx >= r_count) n_state = S_EVICT;
            S_EVICT: if (r_count < w_cap) n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequence one command through the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_idx   <= '0;
                    r_rd_ok <= 1'b0;
                    if (i_valid) begin
                        r_cmd    <= i_cmd;
                        r_acc    <= 1'b0;
                        r_status <= i_cmd.status;
                        if (i_cmd.clear) begin
                            r_head  <= '0;
                            r_count <= '0;
                        end
                    end
                end
                S_PURGE: begin
                    // one read in flight each step; drop expired head
                    r_rd_ok <= (n_state == S_SRCH) ? 1'b0 : !r_rd_ok;
                    if (r_rd_ok && r_count != '0 && r_rd[63:0] < r_cmd.now) begin
                        r_head  <= wrap({{(CW+1-AW){1'b0}}, r_head} + (CW+1)'(1));
                        r_count <= r_count - CW'(1);
                    end
                end
                S_SRCH: begin
                    r_rd_ok <= !r_rd_ok;
                    if (r_rd_ok) r_idx <= r_idx + CW'(1);
                    if (n_state == S_OUT) r_status <= StReplay;
                end
                S_EVICT: begin
                    if (r_count >= w_cap) begin
                        r_head  <= wrap({{(CW+1-AW){1'b0}}, r_head} + (CW+1)'(1));
                        r_count <= r_count - CW'(1);
                    end else begin
                        r_count  <= r_count + CW'(1);
                        r_acc    <= 1'b1;
                        r_status <= StOk;
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("entry count above depth");
    a_acc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_status == StOk) else $error("accept with bad status");
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == StCleared |-> r_count == '0) else $error("clear left entries");
endmodule

FILE: rtl/replay_nonce_cache.sv
// Top level of the replay nonce cache.
// A beat is registered in the front checker, then the back sequencer walks the store
// through a single registered memory read port. A clear or a rejected hello goes
// straight to the result; an accepted hello first purges expired head entries, then
// searches every stored entry, evicts while the store is full and appends; a replay
// that matches entry k (oldest is 0) ends its search there, after the purge.
// The front holds the next beat while the back works, so hellos run one at a time.
// Store contents are undefined after reset.
module replay_nonce_cache import rnc_pkg::*; #(
    parameter int unsigned DEPTH           = DefDepth,
    parameter int unsigned CLIENT_ID_BYTES = DefClientIdBytes,
    parameter int unsigned NONCE_BYTES     = DefNonceBytes
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: client_id_hi, client_id_lo, nonce_hi, nonce_lo, hello_time,
    //        key_identifier, now_time (416 bits)
    input  logic [415:0] s_axis_tdata,
    // tuser: req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: accepted, status, zero pad
    output logic [7:0]   m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    logic [6:0]  r_capacity;
    logic [31:0] r_skew;
    logic        w_q_valid, w_q_ready, w_acc;
    logic [2:0]  w_status;
    t_cmd        w_cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CapReset;
            r_skew     <= SkewReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgCapacity: r_capacity <= i_cfg_data[6:0];
                CfgSkew:     r_skew     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rnc_front #(.CLIENT_ID_BYTES(CLIENT_ID_BYTES), .NONCE_BYTES(NONCE_BYTES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser),
        .i_cid_hi(s_axis_tdata[63:0]),    .i_cid_lo(s_axis_tdata[127:64]),
        .i_non_hi(s_axis_tdata[191:128]), .i_non_lo(s_axis_tdata[255:192]),
        .i_hello_time(s_axis_tdata[319:256]), .i_key_id(s_axis_tdata[351:320]),
        .i_now(s_axis_tdata[415:352]), .i_skew(r_skew),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_cmd(w_cmd)
    );

    rnc_back #(.DEPTH(DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_cmd),
        .i_capacity(r_capacity),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_accepted(w_acc), .o_status(w_status)
    );

    assign m_axis_tdata = {4'd0, w_status, w_acc};
endmodule
